// File: hdl/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// Types, register map, mode codes and reset state of the display-list
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dls_pkg;

   localparam int unsigned LINE_W              = 9;
   localparam int unsigned LINES_PER_FRAME_DEF = 262;
   localparam int unsigned VBLANK_LINE_DEF     = 242;
   localparam int unsigned VISIBLE_LINES_DEF   = 240;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_BYTE  = 2'd3
   } op_type;

   localparam logic [3:0] REG_DMACTL  = 4'h0;
   localparam logic [3:0] REG_DLIST_L = 4'h2;
   localparam logic [3:0] REG_DLIST_H = 4'h3;
   localparam logic [3:0] REG_WSYNC   = 4'hA;
   localparam logic [3:0] REG_VCOUNT  = 4'hB;
   localparam logic [3:0] REG_PENH    = 4'hC;
   localparam logic [3:0] REG_PENV    = 4'hD;
   localparam logic [3:0] REG_NMIEN   = 4'hE;
   localparam logic [3:0] REG_NMIST   = 4'hF;

   localparam logic [3:0] MODE_BLANK  = 4'h0;
   localparam logic [3:0] MODE_JUMP   = 4'h1;
   localparam logic [3:0] MODE_CHAR40 = 4'h4;
   localparam logic [3:0] MODE_CHAR20 = 4'h6;
   localparam logic [3:0] MODE_TALL20 = 4'h7;
   localparam logic [3:0] MODE_MAP2   = 4'hD;
   localparam logic [3:0] MODE_MAP1   = 4'hE;

   localparam logic [7:0]  JVB_MASK    = 8'h4F;
   localparam logic [7:0]  JVB_CODE    = 8'h41;
   localparam logic [15:0] STEP_WIDE   = 16'd40;
   localparam logic [15:0] STEP_NARROW = 16'd20;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_INSTR = 3'd1,
      PH_JLO   = 3'd2,
      PH_JHI   = 3'd3,
      PH_LLO   = 3'd4,
      PH_LHI   = 3'd5
   } phase_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] reg_addr;
      logic [7:0] data;
   } dls_req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              mem_request;
      logic [15:0]       mem_address;
      logic              nmi_pulse;
      logic              wsync_set;
      logic              line_valid;
      logic [3:0]        line_mode;
      logic [3:0]        line_row;
      logic [15:0]       line_base;
      logic              line_error;
      logic [LINE_W-1:0] scan_line;
   } dls_rsp_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_counter;
      logic [15:0][7:0]  reg_file;
      logic [7:0]        current_instr;
      logic              need_instr;
      logic [4:0]        rows_done;
      logic [7:0]        pending_dma;
      logic [15:0]       screen_base;
      phase_type         phase;
      logic [7:0]        jump_low;
   } dls_state_type;

   localparam dls_state_type STATE_RESET = '{
      line_counter:  '0,
      reg_file:      '0,
      current_instr: '0,
      need_instr:    1'b1,
      rows_done:     '0,
      pending_dma:   '0,
      screen_base:   '0,
      phase:         PH_IDLE,
      jump_low:      '0
   };

endpackage

`default_nettype wire

// File: hdl/dls_step.sv
// ----------------------------------------------------------------------------
// dls_step
// Next-state and result logic for one transfer: register access, scanline
// advance, display-list fetch sequencing and line reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_step
   import dls_pkg::*;
#(
   parameter int unsigned LINES_PER_FRAME = LINES_PER_FRAME_DEF,
   parameter int unsigned VBLANK_LINE     = VBLANK_LINE_DEF,
   parameter int unsigned VISIBLE_LINES   = VISIBLE_LINES_DEF
) (
   input  wire dls_state_type cur_state,
   input  wire dls_req_type   item,
   output dls_state_type nxt_state,
   output dls_rsp_type   result
);

   dls_state_type s;
   dls_rsp_type   o;
   logic          do_req;
   logic          do_line;
   logic          do_adv;
   logic          do_dli;
   logic [15:0]   ptr;
   logic [4:0]    rows;
   logic [4:0]    rows_next;
   logic [15:0]   step;
   logic [3:0]    mode;
   logic          jvb;

   always_comb begin
      s        = cur_state;
      o        = '0;
      do_req   = 1'b0;
      do_line  = 1'b0;
      do_adv   = 1'b0;
      do_dli   = 1'b0;
      ptr      = '0;
      rows     = '0;
      rows_next = '0;
      step     = '0;
      mode     = '0;
      jvb      = 1'b0;

      case (item.op)
         OP_WRITE: begin
            if (!(item.reg_addr == REG_VCOUNT || item.reg_addr == REG_PENH ||
                  item.reg_addr == REG_PENV)) begin
               if (item.reg_addr == REG_DMACTL) begin
                  s.pending_dma = item.data;
               end else begin
                  s.reg_file[item.reg_addr] = item.data;
                  if (item.reg_addr == REG_WSYNC) begin
                     o.wsync_set = 1'b1;
                  end
                  if (item.reg_addr == REG_NMIST) begin
                     s.reg_file[REG_NMIST] = '0;
                  end
               end
            end
         end
         OP_READ: begin
            o.read_data = s.reg_file[item.reg_addr];
         end
         OP_TICK: begin
            if (s.phase == PH_IDLE) begin
               if (s.reg_file[REG_DMACTL][1:0] == 2'b00) begin
                  do_adv = 1'b1;
               end else if (s.need_instr) begin
                  s.rows_done = '0;
                  do_req      = 1'b1;
                  s.phase     = PH_INSTR;
               end else begin
                  do_line = 1'b1;
               end
            end
         end
         OP_BYTE: begin
            case (s.phase)
               PH_INSTR: begin
                  s.current_instr = item.data;
                  if (item.data[3:0] == MODE_JUMP) begin
                     do_req  = 1'b1;
                     s.phase = PH_JLO;
                  end else begin
                     s.need_instr = 1'b0;
                     if (item.data[3:0] != MODE_BLANK && item.data[6]) begin
                        do_req  = 1'b1;
                        s.phase = PH_LLO;
                     end else begin
                        do_dli  = 1'b1;
                        do_line = 1'b1;
                        s.phase = PH_IDLE;
                     end
                  end
               end
               PH_JLO: begin
                  s.jump_low = item.data;
                  do_req     = 1'b1;
                  s.phase    = PH_JHI;
               end
               PH_JHI: begin
                  s.reg_file[REG_DLIST_L] = s.jump_low;
                  s.reg_file[REG_DLIST_H] = item.data;
                  if (s.current_instr[6]) begin
                     s.need_instr = 1'b0;
                     s.phase      = PH_IDLE;
                     do_line      = 1'b1;
                  end else begin
                     do_req  = 1'b1;
                     s.phase = PH_INSTR;
                  end
               end
               PH_LLO: begin
                  s.screen_base[7:0] = item.data;
                  do_req             = 1'b1;
                  s.phase            = PH_LHI;
               end
               PH_LHI: begin
                  s.screen_base[15:8] = item.data;
                  do_dli              = 1'b1;
                  do_line             = 1'b1;
                  s.phase             = PH_IDLE;
               end
               default: begin
                  s.phase = PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase

      // issue a display-list fetch and post-increment the pointer
      if (do_req) begin
         ptr                     = {s.reg_file[REG_DLIST_H], s.reg_file[REG_DLIST_L]};
         o.mem_request           = 1'b1;
         o.mem_address           = ptr;
         ptr                     = ptr + 16'd1;
         s.reg_file[REG_DLIST_L] = ptr[7:0];
         s.reg_file[REG_DLIST_H] = ptr[15:8];
      end

      if (do_dli && s.current_instr[7] && s.reg_file[REG_NMIEN][7]) begin
         s.reg_file[REG_NMIST][7] = 1'b1;
         o.nmi_pulse              = 1'b1;
      end

      if (do_line) begin
         jvb = !s.need_instr && ((s.current_instr & JVB_MASK) == JVB_CODE);
         if (s.line_counter < LINE_W'(VISIBLE_LINES) && !jvb) begin
            mode         = s.current_instr[3:0];
            o.line_valid = 1'b1;
            o.line_mode  = mode;
            o.line_row   = s.rows_done[3:0];
            o.line_base  = s.screen_base;
            case (mode)
               MODE_BLANK:  rows = {2'b00, s.current_instr[6:4]} + 5'd1;
               MODE_CHAR40: begin
                  rows = 5'd8;
                  step = STEP_WIDE;
               end
               MODE_CHAR20: begin
                  rows = 5'd8;
                  step = STEP_NARROW;
               end
               MODE_TALL20: begin
                  rows = 5'd16;
                  step = STEP_NARROW;
               end
               MODE_MAP2: begin
                  rows = 5'd2;
                  step = STEP_WIDE;
               end
               MODE_MAP1: begin
                  rows = 5'd1;
                  step = STEP_WIDE;
               end
               default: rows = '0;
            endcase
            if (rows == '0) begin
               o.line_error = 1'b1;
               s.need_instr = 1'b1;
            end else begin
               rows_next   = s.rows_done + 5'd1;
               s.rows_done = rows_next;
               if (rows_next >= rows) begin
                  s.screen_base = s.screen_base + step;
                  s.need_instr  = 1'b1;
               end
            end
         end
         do_adv = 1'b1;
      end

      // advance the scanline; vblank interrupt and frame wrap
      if (do_adv) begin
         s.line_counter = s.line_counter + LINE_W'(1);
         if (s.line_counter == LINE_W'(VBLANK_LINE) && s.reg_file[REG_NMIEN][6]) begin
            s.reg_file[REG_NMIST][6] = 1'b1;
            o.nmi_pulse              = 1'b1;
         end
         if (s.line_counter == LINE_W'(LINES_PER_FRAME)) begin
            s.line_counter = '0;
            if (!s.need_instr && ((s.current_instr & JVB_MASK) == JVB_CODE)) begin
               s.need_instr = 1'b1;
            end
            s.reg_file[REG_DMACTL] = s.pending_dma;
         end
         s.reg_file[REG_VCOUNT] = s.line_counter[LINE_W-1:1];
      end

      o.scan_line = s.line_counter;
   end

   assign nxt_state = s;
   assign result    = o;

endmodule

`default_nettype wire

// File: hdl/display_list_sequencer.sv
// ----------------------------------------------------------------------------
// display_list_sequencer
// Display-list sequencer top level: state register, step logic and output
// register.
// ----------------------------------------------------------------------------
// For every transfer (register write or read, scanline tick, fetched byte)
// the step logic works on the held state and the transfer, and the result
// lands in the output register on the next edge. A new transfer is taken
// every cycle while req_stall is low; req_stall rises only while a result
// sits in the output register and the receiver stalls it. Fetch requests
// appear on rsp_payload.mem_request, and the answering byte is sent back
// as a fetched-byte transfer.
`default_nettype none

module display_list_sequencer
   import dls_pkg::*;
#(
   parameter int unsigned LINES_PER_FRAME = LINES_PER_FRAME_DEF,
   parameter int unsigned VBLANK_LINE     = VBLANK_LINE_DEF,
   parameter int unsigned VISIBLE_LINES   = VISIBLE_LINES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   input  wire dls_req_type req_payload,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output dls_rsp_type rsp_payload
);

   dls_state_type state_ff;
   dls_state_type state_in;
   dls_rsp_type   rsp_payload_ff;
   dls_rsp_type   rsp_payload_in;
   logic          rsp_valid_ff;
   logic          req_accept;

   dls_step #(
      .LINES_PER_FRAME (LINES_PER_FRAME),
      .VBLANK_LINE     (VBLANK_LINE),
      .VISIBLE_LINES   (VISIBLE_LINES)
   ) u_step (
      .cur_state (state_ff),
      .item      (req_payload),
      .nxt_state (state_in),
      .result    (rsp_payload_in)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// File: hdl/dls_checker.sv
// ----------------------------------------------------------------------------
// dls_checker
// Port-level checks of the display-list sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_checker
   import dls_pkg::*;
#(
   parameter int unsigned LINES_PER_FRAME = LINES_PER_FRAME_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   input wire logic  req_valid,
   input wire logic  req_stall,
   input wire logic  rsp_valid,
   input wire logic  rsp_stall,
   input wire dls_rsp_type rsp_payload
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // stall input only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // every input transfer yields a result on the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transfer produced no result");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.scan_line < LINE_W'(LINES_PER_FRAME))
      else $error("scanline out of frame");

   // a fetch request never coincides with a sequenced line
   a_req_vs_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mem_request |-> !rsp_payload.line_valid)
      else $error("fetch request and line in one result");

endmodule

bind display_list_sequencer dls_checker #(
   .LINES_PER_FRAME (LINES_PER_FRAME)
) u_dls_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the display-list sequencer. A scoreboard class
// predicts each result from the accepted transfers and compares it field by
// field. Stimulus is a short directed opening, then random bus accesses and
// scanline ticks, with fetch requests answered by generated display lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dls_check_pkg;
   import dls_pkg::*;

   class dls_scoreboard;
      logic [LINE_W-1:0] line_q;
      logic [7:0]        regs [16];
      logic [7:0]        instr;
      bit                need_q;
      logic [4:0]        rows_q;
      logic [7:0]        dma_next;
      logic [15:0]       base_q;
      phase_type         phase;
      logic [7:0]        jlo;
      dls_rsp_type       expected_q[$];
      dls_rsp_type       r;
      int unsigned       errors, transfers, lines, bad_modes, fetches, nmis, wraps;

      function new();
         line_q   = '0;
         foreach (regs[i]) regs[i] = '0;
         instr    = '0;
         need_q   = 1'b1;
         rows_q   = '0;
         dma_next = '0;
         base_q   = '0;
         phase    = PH_IDLE;
         jlo      = '0;
      endfunction

      function logic [15:0] dl_ptr();
         return {regs[REG_DLIST_H], regs[REG_DLIST_L]};
      endfunction

      function void set_ptr(logic [15:0] p);
         regs[REG_DLIST_L] = p[7:0];
         regs[REG_DLIST_H] = p[15:8];
      endfunction

      function bit jvb_wait();
         return !need_q && ((instr & JVB_MASK) == JVB_CODE);
      endfunction

      function void fetch_req();
         logic [15:0] p;
         p = dl_ptr();
         r.mem_request = 1'b1;
         r.mem_address = p;
         set_ptr(p + 16'd1);
      endfunction

      function void next_line();
         line_q = line_q + 1'b1;
         if (line_q == VBLANK_LINE_DEF && regs[REG_NMIEN][6]) begin
            regs[REG_NMIST][6] = 1'b1;
            r.nmi_pulse = 1'b1;
         end
         if (line_q == LINES_PER_FRAME_DEF) begin
            line_q = '0;
            if (jvb_wait()) need_q = 1'b1;
            regs[REG_DMACTL] = dma_next;
            wraps++;
         end
         regs[REG_VCOUNT] = 8'(line_q >> 1);
      endfunction

      function void emit_line();
         logic [3:0]  m;
         int unsigned nrows;
         logic [15:0] step;
         if (line_q < VISIBLE_LINES_DEF && !jvb_wait()) begin
            m = instr[3:0];
            r.line_valid = 1'b1;
            r.line_mode  = m;
            r.line_row   = rows_q[3:0];
            r.line_base  = base_q;
            nrows = 0;
            step  = '0;
            case (m)
               MODE_BLANK:  nrows = int'(instr[6:4]) + 1;
               MODE_CHAR40: begin nrows = 8;  step = STEP_WIDE;   end
               MODE_CHAR20: begin nrows = 8;  step = STEP_NARROW; end
               MODE_TALL20: begin nrows = 16; step = STEP_NARROW; end
               MODE_MAP2:   begin nrows = 2;  step = STEP_WIDE;   end
               MODE_MAP1:   begin nrows = 1;  step = STEP_WIDE;   end
               default: ;
            endcase
            if (nrows == 0) begin
               r.line_error = 1'b1;
               need_q = 1'b1;
            end else begin
               rows_q = rows_q + 1'b1;
               if (rows_q >= nrows) begin
                  base_q = base_q + step;
                  need_q = 1'b1;
               end
            end
         end
         next_line();
      endfunction

      function void dli_check();
         if (instr[7] && regs[REG_NMIEN][7]) begin
            regs[REG_NMIST][7] = 1'b1;
            r.nmi_pulse = 1'b1;
         end
      endfunction

      function void take_byte(logic [7:0] d);
         case (phase)
            PH_INSTR: begin
               instr = d;
               if (d[3:0] == MODE_JUMP) begin
                  fetch_req();
                  phase = PH_JLO;
               end else begin
                  need_q = 1'b0;
                  if (d[3:0] != MODE_BLANK && d[6]) begin
                     fetch_req();
                     phase = PH_LLO;
                  end else begin
                     dli_check();
                     phase = PH_IDLE;
                     emit_line();
                  end
               end
            end
            PH_JLO: begin
               jlo = d;
               fetch_req();
               phase = PH_JHI;
            end
            PH_JHI: begin
               set_ptr({d, jlo});
               if (instr[6]) begin
                  need_q = 1'b0;
                  phase = PH_IDLE;
                  emit_line();
               end else begin
                  fetch_req();
                  phase = PH_INSTR;
               end
            end
            PH_LLO: begin
               base_q[7:0] = d;
               fetch_req();
               phase = PH_LHI;
            end
            PH_LHI: begin
               base_q[15:8] = d;
               dli_check();
               phase = PH_IDLE;
               emit_line();
            end
            default: phase = PH_IDLE;
         endcase
      endfunction

      // Predict the result of one accepted transfer and queue it.
      function void note_transfer(dls_req_type t);
         r = '0;
         case (t.op)
            OP_WRITE: begin
               if (!(t.reg_addr inside {REG_VCOUNT, REG_PENH, REG_PENV})) begin
                  if (t.reg_addr == REG_DMACTL) begin
                     dma_next = t.data;
                  end else begin
                     regs[t.reg_addr] = t.data;
                     if (t.reg_addr == REG_WSYNC) r.wsync_set = 1'b1;
                     if (t.reg_addr == REG_NMIST) regs[REG_NMIST] = '0;
                  end
               end
            end
            OP_READ: r.read_data = regs[t.reg_addr];
            OP_TICK: begin
               if (phase == PH_IDLE) begin
                  if (regs[REG_DMACTL][1:0] == 2'b00) begin
                     next_line();
                  end else if (need_q) begin
                     rows_q = '0;
                     fetch_req();
                     phase = PH_INSTR;
                  end else begin
                     emit_line();
                  end
               end
            end
            default: begin
               if (phase != PH_IDLE) take_byte(t.data);
            end
         endcase
         r.scan_line = line_q;
         transfers++;
         if (r.line_valid)  lines++;
         if (r.line_error)  bad_modes++;
         if (r.mem_request) fetches++;
         if (r.nmi_pulse)   nmis++;
         expected_q.push_back(r);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(dls_rsp_type got);
         dls_rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         check_field("read_data",   want.read_data,   got.read_data);
         check_field("mem_request", want.mem_request, got.mem_request);
         check_field("mem_address", want.mem_address, got.mem_address);
         check_field("nmi_pulse",   want.nmi_pulse,   got.nmi_pulse);
         check_field("wsync_set",   want.wsync_set,   got.wsync_set);
         check_field("line_valid",  want.line_valid,  got.line_valid);
         check_field("line_mode",   want.line_mode,   got.line_mode);
         check_field("line_row",    want.line_row,    got.line_row);
         check_field("line_base",   want.line_base,   got.line_base);
         check_field("line_error",  want.line_error,  got.line_error);
         check_field("scan_line",   want.scan_line,   got.scan_line);
      endfunction
   endclass

endpackage

module tb_top
   import dls_pkg::*, dls_check_pkg::*;
();

   localparam int unsigned NUM_RANDOM  = 375;
   localparam int unsigned DRAIN       = 10;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dls_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dls_rsp_type rsp_payload;

   dls_scoreboard sb;
   bit            calm;
   int unsigned   cycle_count;

   display_list_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if (req_valid && !req_stall) sb.note_transfer(req_payload);
      end
   end

   function automatic dls_req_type xfer(op_type op, logic [3:0] a, logic [7:0] d);
      dls_req_type t;
      t.op       = op;
      t.reg_addr = a;
      t.data     = d;
      return t;
   endfunction

   // Display-list byte for the fetch phase the block is in.
   function automatic logic [7:0] dl_byte(phase_type ph);
      logic [7:0]  b;
      logic [3:0]  m;
      int unsigned roll;
      b = 8'($urandom);
      if (ph == PH_INSTR) begin
         roll = $urandom_range(0, 99);
         if (roll < 82) begin
            do m = 4'($urandom);
            while (!(m inside {MODE_BLANK, MODE_CHAR40, MODE_CHAR20, MODE_TALL20,
                               MODE_MAP2, MODE_MAP1}));
            b[3:0] = m;
         end else if (roll < 92) begin
            b[3:0] = MODE_JUMP;
            b[6]   = ($urandom_range(0, 7) == 0);
         end else begin
            do m = 4'($urandom);
            while (m inside {MODE_BLANK, MODE_JUMP, MODE_CHAR40, MODE_CHAR20,
                             MODE_TALL20, MODE_MAP2, MODE_MAP1});
            b[3:0] = m;
         end
      end
      return b;
   endfunction

   function automatic dls_req_type pick_transfer();
      dls_req_type t;
      int unsigned roll;
      t.op       = OP_TICK;
      t.reg_addr = 4'($urandom);
      t.data     = 8'($urandom);
      if (sb.phase != PH_IDLE && $urandom_range(0, 99) < 85) begin
         t.op   = OP_BYTE;
         t.data = dl_byte(sb.phase);
      end else if (sb.regs[REG_DMACTL][1:0] == 2'b00 && $urandom_range(0, 99) < 85) begin
         t.op = OP_TICK;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 62) begin
            t.op = OP_TICK;
         end else if (roll < 74) begin
            t.op = OP_READ;
         end else if (roll < 92) begin
            t.op = OP_WRITE;
            if (t.reg_addr == REG_DMACTL && $urandom_range(0, 99) < 85 && t.data[1:0] == 2'b00)
               t.data[1:0] = 2'($urandom_range(1, 3));
         end else begin
            t.op = OP_BYTE;
         end
      end
      return t;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send(dls_req_type t);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : receiver
      int unsigned hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 12);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin : stimulus
      dls_req_type plan[$];
      sb = new();
      plan.push_back(xfer(OP_READ,  REG_NMIST,   8'h00));
      plan.push_back(xfer(OP_READ,  REG_VCOUNT,  8'h00));
      plan.push_back(xfer(OP_WRITE, REG_VCOUNT,  8'hFF));
      plan.push_back(xfer(OP_WRITE, REG_PENH,    8'hFF));
      plan.push_back(xfer(OP_WRITE, REG_PENV,    8'h00));
      plan.push_back(xfer(OP_READ,  REG_VCOUNT,  8'hFF));
      plan.push_back(xfer(OP_READ,  REG_PENH,    8'h00));
      plan.push_back(xfer(OP_WRITE, 4'h1,        8'hFF));
      plan.push_back(xfer(OP_READ,  4'h1,        8'h00));
      plan.push_back(xfer(OP_WRITE, 4'h9,        8'h00));
      plan.push_back(xfer(OP_WRITE, REG_WSYNC,   8'hFF));
      plan.push_back(xfer(OP_WRITE, REG_NMIEN,   8'hC0));
      plan.push_back(xfer(OP_WRITE, REG_NMIST,   8'hFF));
      plan.push_back(xfer(OP_READ,  REG_NMIST,   8'h00));
      plan.push_back(xfer(OP_WRITE, REG_DLIST_L, 8'hFF));
      plan.push_back(xfer(OP_WRITE, REG_DLIST_H, 8'hFF));
      plan.push_back(xfer(OP_READ,  REG_DLIST_H, 8'h00));
      plan.push_back(xfer(OP_BYTE,  4'hF,        8'hFF));
      plan.push_back(xfer(OP_BYTE,  4'h0,        8'h00));
      plan.push_back(xfer(OP_TICK,  4'h5,        8'hAA));
      plan.push_back(xfer(OP_TICK,  4'hA,        8'h55));
      plan.push_back(xfer(OP_READ,  REG_VCOUNT,  8'h00));
      plan.push_back(xfer(OP_WRITE, REG_DMACTL,  8'h23));
      plan.push_back(xfer(OP_READ,  REG_DMACTL,  8'h00));
      plan.push_back(xfer(OP_READ,  REG_NMIEN,   8'h00));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send(plan[i]);
      for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
         calm = (i % 200) >= 160;
         send(pick_transfer());
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      $display("tb_top: %0d transfers, %0d visible lines (%0d bad modes), %0d fetches",
               sb.transfers, sb.lines, sb.bad_modes, sb.fetches);
      $display("tb_top: %0d interrupts, %0d frame wraps, %0d mismatches",
               sb.nmis, sb.wraps, sb.errors);
      if (sb.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/dls_pkg.sv
hdl/dls_step.sv
hdl/display_list_sequencer.sv
hdl/dls_checker.sv
bench/tb_top.sv
